// ----- design/asau_pkg.sv -----
// ----------------------------------------------------------------------------
// asau_pkg
// Shared widths, register indexes and bundle types for the ADC scan
// sequencer averaging unit.
// ----------------------------------------------------------------------------
package asau_pkg;

	// number of scan slots that the hardware holds
	localparam int unsigned MAX_SLOTS = 8;

	localparam int unsigned SLOT_W    = 3;
	localparam int unsigned ACTIVE_W  = 4;
	localparam int unsigned CHAN_W    = 5;
	localparam int unsigned SHIFT_W   = 3;
	localparam int unsigned SAMPLE_W  = 10;
	localparam int unsigned SUM_W     = 16;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned AVG_W     = 10;
	localparam int unsigned CMAP_W    = CHAN_W * MAX_SLOTS;
	localparam int unsigned SMAP_W    = SHIFT_W * MAX_SLOTS;
	localparam int unsigned CFG_W     = CMAP_W;
	localparam int unsigned CFG_IDX_W = 2;

	// stream payload widths, padded to whole bytes
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_SLOTS = 2'd0,
		REG_CHANNEL_MAP  = 2'd1,
		REG_SHIFT_MAP    = 2'd2
	} reg_idx_t;

	// configuration register bundle
	typedef struct packed {
		logic [ACTIVE_W-1:0] active_slots;
		logic [CMAP_W-1:0]   channel_map;
		logic [SMAP_W-1:0]   shift_map;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic              avg_ready;
		logic [SLOT_W-1:0] done_slot;
		logic [AVG_W-1:0]  average;
		logic [CHAN_W-1:0] next_channel;
	} result_t;

endpackage

// ----- design/asau_cfg.sv -----
// ----------------------------------------------------------------------------
// asau_cfg
// Configuration register file: slot count, channel map and shift map,
// written through a plain write port.
// ----------------------------------------------------------------------------
module asau_cfg
	import asau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_slots <= ACTIVE_W'(1);
			cfg_q.channel_map  <= '0;
			cfg_q.shift_map    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ACTIVE_SLOTS: cfg_q.active_slots <= cfg_data[ACTIVE_W-1:0];
				REG_CHANNEL_MAP:  cfg_q.channel_map  <= cfg_data[CMAP_W-1:0];
				REG_SHIFT_MAP:    cfg_q.shift_map    <= cfg_data[SMAP_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/asau_accum.sv -----
// ----------------------------------------------------------------------------
// asau_accum
// Per-slot accumulator: sums samples, counts them against 2^shift, forms
// the average and advances the scan slot round-robin.
// ----------------------------------------------------------------------------
module asau_accum
	import asau_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] sample,
	output result_t             result
);

	logic [SLOT_W-1:0]   slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [SHIFT_W-1:0]  sh;
	logic [SUM_W-1:0]    sum_n;
	logic [CNT_W-1:0]    cnt_n;
	logic                hit;
	logic [SUM_W-1:0]    sum_shr;
	logic [ACTIVE_W-1:0] nxt_wide;
	logic [SLOT_W-1:0]   nxt_slot;
	logic [SLOT_W-1:0]   slot_after;

	// running sum and count, wrapping at their widths
	always_comb begin
		sh      = cfg.shift_map[SHIFT_W*slot_q +: SHIFT_W];
		sum_n   = sum_q + SUM_W'(sample);
		cnt_n   = cnt_q + CNT_W'(1);
		hit     = (cnt_n == (CNT_W'(1) << sh));
		sum_shr = sum_n >> sh;
	end

	// round-robin advance over the active slots
	always_comb begin
		nxt_wide = ACTIVE_W'(slot_q) + ACTIVE_W'(1);
		if (nxt_wide >= cfg.active_slots || nxt_wide >= ACTIVE_W'(MAX_SLOTS)) begin
			nxt_slot = '0;
		end else begin
			nxt_slot = nxt_wide[SLOT_W-1:0];
		end
		slot_after = hit ? nxt_slot : slot_q;
	end

	// result fields
	always_comb begin
		result.avg_ready    = hit;
		result.done_slot    = hit ? slot_q : '0;
		result.average      = hit ? sum_shr[AVG_W-1:0] : '0;
		result.next_channel = cfg.channel_map[CHAN_W*slot_after +: CHAN_W];
	end

	// state update on each processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			slot_q <= slot_after;
			sum_q  <= hit ? '0 : sum_n;
			cnt_q  <= hit ? '0 : cnt_n;
		end
	end

endmodule

// ----- design/adc_scan_sequencer_averaging_unit.sv -----
// ----------------------------------------------------------------------------
// adc_scan_sequencer_averaging_unit
// Round-robin ADC scan with per-slot oversampling average; every sample
// yields one result carrying the channel to convert next.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: sample[9:0]
//  m_*     | out       | m_tvalid/m_tready  | tuser: avg_ready; tdata: done_slot,
//          |           |                    |   average, next_channel
//  cfg_*   | in        | cfg_we             | cfg_idx, cfg_data
//
// One sample per clock sustained while m_tready holds; each sample passes the
// input register, then the result register, before its result is valid.
// The accumulate, compare and slot advance sit between those two registers.
// Reset clears the pipeline valids, slot, sum and count; config resets to
// one active slot with all channels and shifts zero.
// A stalled output holds its result; the input register keeps taking
// samples until both stages are full.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_averaging_unit
	import asau_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// sample stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] sample
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] done_slot, [12:3] average,
	                                          // [17:13] next_channel
	output logic                   m_tuser,   // [0] avg_ready
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t                cfg;
	result_t             result;
	result_t             result_s2;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                valid_s2;
	logic                out_free;
	logic                step;

	asau_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	asau_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.sample (sample_s1),
		.result (result)
	);

	// pipeline flow control
	assign out_free = !valid_s2 || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	// output packing
	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.avg_ready;
	assign m_tdata  = {(OUT_TDATA_W-SLOT_W-AVG_W-CHAN_W)'(0),
		result_s2.next_channel, result_s2.average, result_s2.done_slot};

endmodule

// ----- sim/adc_scan_sequencer_averaging_unit_test.sv -----
// ----------------------------------------------------------------------------
// adc_scan_sequencer_averaging_unit_test
// Streams converter samples into the scan averaging unit under several slot,
// channel and shift settings. A scoreboard tracks the running sum, count and
// scan slot and checks every result field against its own prediction.
// ----------------------------------------------------------------------------

// tracks the averaging state and holds the results still due from the block
class scan_average_scoreboard;
	logic [asau_pkg::ACTIVE_W-1:0] active_slots;
	logic [asau_pkg::CMAP_W-1:0]   channel_map;
	logic [asau_pkg::SMAP_W-1:0]   shift_map;
	logic [asau_pkg::SLOT_W-1:0]   slot;
	logic [asau_pkg::SUM_W-1:0]    sum;
	logic [asau_pkg::CNT_W-1:0]    count;
	asau_pkg::result_t             expected_results[$];
	int                            mismatch_count;

	function new();
		active_slots   = 1;
		channel_map    = '0;
		shift_map      = '0;
		slot           = '0;
		sum            = '0;
		count          = '0;
		mismatch_count = 0;
	endfunction

	// mirror of a register write
	function void set_register(asau_pkg::reg_idx_t idx, logic [asau_pkg::CFG_W-1:0] value);
		case (idx)
			asau_pkg::REG_ACTIVE_SLOTS: active_slots = value[asau_pkg::ACTIVE_W-1:0];
			asau_pkg::REG_CHANNEL_MAP:  channel_map  = value[asau_pkg::CMAP_W-1:0];
			asau_pkg::REG_SHIFT_MAP:    shift_map    = value[asau_pkg::SMAP_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	// accumulate one accepted sample and queue the result it yields
	function void note_sample(logic [asau_pkg::SAMPLE_W-1:0] sample);
		logic [asau_pkg::SHIFT_W-1:0] sh;
		logic [asau_pkg::SUM_W-1:0]   shifted;
		int                           nxt;
		asau_pkg::result_t            res;
		sh    = shift_map[slot*asau_pkg::SHIFT_W +: asau_pkg::SHIFT_W];
		sum   = sum + asau_pkg::SUM_W'(sample);
		count = count + 1'b1;
		res   = '0;
		if (int'(count) == (1 << sh)) begin
			shifted       = sum >> sh;
			res.avg_ready = 1'b1;
			res.done_slot = slot;
			res.average   = shifted[asau_pkg::AVG_W-1:0];
			sum           = '0;
			count         = '0;
			// round-robin advance, a slot past the active range falls back to zero
			nxt = int'(slot) + 1;
			if (nxt >= int'(active_slots) || nxt >= int'(asau_pkg::MAX_SLOTS))
				nxt = 0;
			slot = asau_pkg::SLOT_W'(nxt);
		end
		res.next_channel = channel_map[slot*asau_pkg::CHAN_W +: asau_pkg::CHAN_W];
		expected_results.push_back(res);
	endfunction

	// compare one accepted result with the oldest prediction
	function void check_result(logic tuser, logic [asau_pkg::OUT_TDATA_W-1:0] tdata);
		asau_pkg::result_t want;
		asau_pkg::result_t got;
		if (expected_results.size() == 0) begin
			$error("result with no prediction pending: tuser %0b tdata %h", tuser, tdata);
			mismatch_count++;
			return;
		end
		want             = expected_results.pop_front();
		got.avg_ready    = tuser;
		got.done_slot    = tdata[2:0];
		got.average      = tdata[12:3];
		got.next_channel = tdata[17:13];
		if (got.avg_ready !== want.avg_ready) begin
			$error("avg_ready mismatch: expected %0d, actual %0d", want.avg_ready, got.avg_ready);
			mismatch_count++;
		end
		if (got.done_slot !== want.done_slot) begin
			$error("done_slot mismatch: expected %0d, actual %0d", want.done_slot, got.done_slot);
			mismatch_count++;
		end
		if (got.average !== want.average) begin
			$error("average mismatch: expected %0d, actual %0d", want.average, got.average);
			mismatch_count++;
		end
		if (got.next_channel !== want.next_channel) begin
			$error("next_channel mismatch: expected %0d, actual %0d",
				want.next_channel, got.next_channel);
			mismatch_count++;
		end
	endfunction
endclass

module adc_scan_sequencer_averaging_unit_test
	import asau_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [9:0] sample
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [2:0] done_slot, [12:3] average,
	                                         // [17:13] next_channel
	logic                   m_tuser;         // [0] avg_ready
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx = REG_ACTIVE_SLOTS;
	logic [CFG_W-1:0]       cfg_data = '0;

	scan_average_scoreboard scoreboard = new();
	bit                     bursts_on = 1'b0;
	int                     random_items;

	adc_scan_sequencer_averaging_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// result side: random stall bursts on m_tready
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			scoreboard.check_result(m_tuser, m_tdata);
	end

	// one sample request, entered and left at a falling edge
	task automatic push_sample(logic [SAMPLE_W-1:0] value);
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(value);
		do @(posedge clk); while (s_tready !== 1'b1);
		scoreboard.note_sample(value);
		@(negedge clk);
	endtask

	// converter value with the rails favored
	function automatic logic [SAMPLE_W-1:0] pick_sample(bit rail_heavy);
		int roll;
		roll = $urandom_range(0, 7);
		if (rail_heavy)
			return (roll < 6) ? 10'h3FF : SAMPLE_W'($urandom);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return 10'h3FF;
		return SAMPLE_W'($urandom);
	endfunction

	// drain, write the selected registers, then stream random samples
	task automatic run_phase(logic [ACTIVE_W-1:0] active, logic [CMAP_W-1:0] cmap,
			logic [SMAP_W-1:0] smap, logic [2:0] reg_mask, int n_items, bit rail_heavy);
		logic [CFG_W-1:0] value;
		s_tvalid <= 1'b0;
		while (scoreboard.pending() != 0) @(negedge clk);
		for (int r = 0; r < 3; r++) begin
			if (reg_mask[r]) begin
				case (reg_idx_t'(r))
					REG_ACTIVE_SLOTS: value = CFG_W'(active);
					REG_CHANNEL_MAP:  value = CFG_W'(cmap);
					default:          value = CFG_W'(smap);
				endcase
				cfg_we   <= 1'b1;
				cfg_idx  <= reg_idx_t'(r);
				cfg_data <= value;
				@(negedge clk);
				scoreboard.set_register(reg_idx_t'(r), value);
			end
		end
		cfg_we <= 1'b0;
		repeat (n_items) push_sample(pick_sample(rail_heavy));
	endtask

	// random shift map, mostly short averages with an occasional long one
	function automatic logic [SMAP_W-1:0] pick_shift_map();
		logic [SMAP_W-1:0] smap;
		for (int k = 0; k < MAX_SLOTS; k++)
			smap[k*SHIFT_W +: SHIFT_W] = ($urandom_range(0, 9) == 0) ?
				SHIFT_W'($urandom_range(4, 7)) : SHIFT_W'($urandom_range(0, 3));
		return smap;
	endfunction

	// stimulus
	initial begin
		logic [ACTIVE_W-1:0] active;
		logic [CMAP_W-1:0]   cmap;
		int                  n_items;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		bursts_on = 1'b1;

		// reset settings: every sample is its own average on slot 0
		push_sample(10'h000);
		push_sample(10'h3FF);
		push_sample(10'h155);
		push_sample(10'h2AA);

		// all eight slots with every channel at its top value
		run_phase(4'd8, {CMAP_W{1'b1}}, '0, 3'b011, 0, 1'b0);
		repeat (13) push_sample(pick_sample(1'b0));

		// slot left beyond a shrunk scan range returns to zero
		run_phase(4'd2, '0, '0, 3'b001, 2, 1'b0);

		// zero active slots acts as one
		run_phase(4'd0, '0, '0, 3'b001, 2, 1'b0);

		// more than eight active slots acts as eight
		run_phase(4'd15, 40'h7B_DE_F7_BD_EF, '0, 3'b011, 3, 1'b0);

		// longest average with rail samples, so the sum wraps
		run_phase(4'd1, '0, {SMAP_W{1'b1}}, 3'b111, 256, 1'b1);
		random_items = 256;

		// random settings, switched mid-average
		while (random_items < 1100) begin
			bursts_on = (random_items < 950) && ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 5))
				0:       active = 4'd0;
				1:       active = 4'd15;
				2:       active = 4'd8;
				default: active = ACTIVE_W'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 5))
				0:       cmap = '0;
				1:       cmap = {CMAP_W{1'b1}};
				default: cmap = CMAP_W'({$urandom, $urandom});
			endcase
			n_items = $urandom_range(20, 80);
			run_phase(active, cmap, pick_shift_map(), 3'($urandom_range(1, 7)), n_items,
				$urandom_range(0, 5) == 0);
			random_items += n_items;
		end

		// drain and finish
		s_tvalid <= 1'b0;
		while (scoreboard.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (scoreboard.mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
